[hdl/nine_patch_source_mapper_defines.svh]
// Assertion macros shared by the nine-patch source mapper RTL.
// No dependencies; included by the files that assert.
`ifndef NINE_PATCH_SOURCE_MAPPER_DEFINES_SVH
`define NINE_PATCH_SOURCE_MAPPER_DEFINES_SVH
`ifndef ASSERT_OFF
`define NPSM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NPSM_ASSERT_RST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NPSM_ASSERT(label, clk, rst_n, prop, msg)
`define NPSM_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

[hdl/npsm_pkg.sv]
// Package for the nine-patch source mapper: widths, codes and shared types.
// No dependencies.
package npsm_pkg;
	localparam int ADDR_W     = 18;
	localparam int COORD_W    = 16;
	localparam int MARGIN_W   = 8;
	localparam int MOD_STAGES = COORD_W;
	localparam int unsigned VRAM_BYTES = 262144;

	localparam logic [2:0] REG_SPRITE_BASE   = 3'd0;
	localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd1;
	localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd2;
	localparam logic [2:0] REG_MARGIN_WIDTH  = 3'd3;
	localparam logic [2:0] REG_CORNER_HEIGHT = 3'd4;
	localparam logic [2:0] REG_DEST_WIDTH    = 3'd5;
	localparam logic [2:0] REG_DEST_HEIGHT   = 3'd6;
	localparam logic [2:0] REG_PIXEL_BYTES   = 3'd7;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_OUTSIDE = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0]   sprite_base;
		logic [COORD_W-1:0]  sprite_width;
		logic [MARGIN_W-1:0] margin_width;
		logic [MARGIN_W-1:0] corner_height;
		logic [COORD_W-1:0]  dest_width;
		logic [COORD_W-1:0]  dest_height;
		logic [COORD_W-1:0]  mid_sw;
		logic [COORD_W-1:0]  mid_sh;
		logic                wide;
		logic                invalid;
	} cfg_t;

	typedef struct packed {
		logic               mid_x;
		logic [COORD_W-1:0] alt_x;
		logic               mid_y;
		logic [COORD_W-1:0] alt_y;
		logic               outside;
		logic [COORD_W-1:0] screen_x;
		logic [COORD_W-1:0] screen_y;
	} side_t;
endpackage

[hdl/npsm_if.sv]
// Channel interfaces of the nine-patch source mapper.
// No dependencies.
interface npsm_in_if;
	logic               valid;
	logic               ready;
	logic        [15:0] rel_x;
	logic        [15:0] rel_y;
	logic signed [15:0] origin_x;
	logic signed [15:0] origin_y;
	modport source (output valid, rel_x, rel_y, origin_x, origin_y, input ready);
	modport sink (input valid, rel_x, rel_y, origin_x, origin_y, output ready);
endinterface

interface npsm_out_if;
	logic               valid;
	logic               ready;
	logic        [17:0] source_address;
	logic signed [15:0] screen_x;
	logic signed [15:0] screen_y;
	logic        [1:0]  status;
	modport source (output valid, source_address, screen_x, screen_y, status, input ready);
	modport sink (input valid, source_address, screen_x, screen_y, status, output ready);
endinterface

interface npsm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [17:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hdl/npsm_cfg.sv]
// Configuration registers and derived settings checks.
// Depends on npsm_pkg and npsm_cfg_if.
module npsm_cfg import npsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	npsm_cfg_if.sink   cfg,
	output cfg_t       settings
);
	logic [ADDR_W-1:0]    sprite_base_q;
	logic [COORD_W-1:0]   sprite_width_q, sprite_height_q, dest_width_q, dest_height_q;
	logic [MARGIN_W-1:0]  margin_width_q, corner_height_q;
	logic [1:0]           pixel_bytes_q;
	logic [2*COORD_W-1:0] size_q;
	logic                 invalid_q;
	logic [MARGIN_W:0]    two_cw, two_ch;
	logic                 geom_bad, mid_bad, wide;
	logic [33:0]          end_addr;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sprite_base_q   <= '0;
			sprite_width_q  <= '0;
			sprite_height_q <= '0;
			margin_width_q  <= '0;
			corner_height_q <= '0;
			dest_width_q    <= '0;
			dest_height_q   <= '0;
			pixel_bytes_q   <= 2'd1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SPRITE_BASE:   sprite_base_q   <= cfg.data;
				REG_SPRITE_WIDTH:  sprite_width_q  <= cfg.data[COORD_W-1:0];
				REG_SPRITE_HEIGHT: sprite_height_q <= cfg.data[COORD_W-1:0];
				REG_MARGIN_WIDTH:  margin_width_q  <= cfg.data[MARGIN_W-1:0];
				REG_CORNER_HEIGHT: corner_height_q <= cfg.data[MARGIN_W-1:0];
				REG_DEST_WIDTH:    dest_width_q    <= cfg.data[COORD_W-1:0];
				REG_DEST_HEIGHT:   dest_height_q   <= cfg.data[COORD_W-1:0];
				REG_PIXEL_BYTES:   pixel_bytes_q   <= cfg.data[1:0];
				default: ;
			endcase
		end
	end

	assign wide   = (pixel_bytes_q == 2'd2);
	assign two_cw = {margin_width_q, 1'b0};
	assign two_ch = {corner_height_q, 1'b0};
	assign geom_bad = (sprite_width_q < COORD_W'(two_cw)) || (sprite_height_q < COORD_W'(two_ch))
		|| (dest_width_q < COORD_W'(two_cw)) || (dest_height_q < COORD_W'(two_ch));
	assign mid_bad = ((sprite_width_q == COORD_W'(two_cw)) && (dest_width_q != COORD_W'(two_cw)))
		|| ((sprite_height_q == COORD_W'(two_ch)) && (dest_height_q != COORD_W'(two_ch)));
	assign end_addr = 34'(sprite_base_q) + (34'(size_q) << wide);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= '0;
			invalid_q <= 1'b0;
		end else begin
			size_q    <= sprite_width_q * sprite_height_q;
			invalid_q <= geom_bad || mid_bad || (end_addr > 34'(VRAM_BYTES));
		end
	end

	always_comb begin
		settings.sprite_base   = sprite_base_q;
		settings.sprite_width  = sprite_width_q;
		settings.margin_width  = margin_width_q;
		settings.corner_height = corner_height_q;
		settings.dest_width    = dest_width_q;
		settings.dest_height   = dest_height_q;
		settings.mid_sw        = sprite_width_q - COORD_W'(two_cw);
		settings.mid_sh        = sprite_height_q - COORD_W'(two_ch);
		settings.wide          = wide;
		settings.invalid       = invalid_q;
	end
endmodule

[hdl/npsm_mod.sv]
// Pipelined restoring remainder: one quotient bit per stage.
// Depends on npsm_pkg.
module npsm_mod import npsm_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [COORD_W-1:0] num,
	input  logic [COORD_W-1:0] div,
	output logic [COORD_W-1:0] rem
);
	logic [COORD_W-1:0] rem_s [MOD_STAGES];
	logic [COORD_W-1:0] num_s [MOD_STAGES];
	logic [COORD_W-1:0] rem_nx [MOD_STAGES];
	logic [COORD_W-1:0] num_nx [MOD_STAGES];

	always_comb begin
		logic [COORD_W:0]   t;
		logic [COORD_W-1:0] r_in, n_in;
		for (int i = 0; i < MOD_STAGES; i++) begin
			r_in = (i == 0) ? '0 : rem_s[i-1];
			n_in = (i == 0) ? num : num_s[i-1];
			t = {r_in, n_in[COORD_W-1]};
			if (t >= {1'b0, div})
				t = t - {1'b0, div};
			rem_nx[i] = t[COORD_W-1:0];
			num_nx[i] = {n_in[COORD_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s <= rem_nx;
			num_s <= num_nx;
		end
	end

	assign rem = rem_s[MOD_STAGES-1];
endmodule

[hdl/nine_patch_source_mapper.sv]
// Nine-patch source mapper: one destination pixel per clock while the output is not
// stalled, mapped to its source byte address. The pipeline is an entry stage, sixteen
// remainder stages (one per coordinate bit) that tile the middle region, a multiply
// stage and the output register. Settings settle through registered checks after a write.
// Depends on npsm_pkg, the interfaces, npsm_cfg and npsm_mod.
`include "nine_patch_source_mapper_defines.svh"
module nine_patch_source_mapper import npsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	npsm_cfg_if.sink   cfg,
	npsm_in_if.sink    pix_in,
	npsm_out_if.source pix_out
);
	cfg_t                 settings;
	logic                 en;
	logic                 v_s1, v_s18, v_s19;
	logic [MOD_STAGES-1:0] v_smod;
	side_t                side_s1, side_s18;
	side_t                side_smod [MOD_STAGES];
	logic [COORD_W-1:0]   dx_s1, dy_s1, rem_x, rem_y;
	logic [2*COORD_W-1:0] prod_s18;
	logic [COORD_W-1:0]   sx_s18, sx, sy;
	side_t                side_in;
	logic [ADDR_W-1:0]    lin, scaled, addr_s19;
	logic [1:0]           status_s19;
	logic [COORD_W-1:0]   scr_x_s19, scr_y_s19;
	logic [COORD_W:0]     mid_end_x, mid_end_y;
	logic                 lead_x, lead_y;
	side_t                side_last;

	npsm_cfg u_cfg (.clk(clk), .arst_n(arst_n), .cfg(cfg), .settings(settings));

	assign en = !v_s19 || pix_out.ready;
	assign pix_in.ready = en;

	always_comb begin
		mid_end_x = {1'b0, settings.dest_width} - {9'b0, settings.margin_width};
		mid_end_y = {1'b0, settings.dest_height} - {9'b0, settings.corner_height};
		lead_x = pix_in.rel_x < COORD_W'(settings.margin_width);
		lead_y = pix_in.rel_y < COORD_W'(settings.corner_height);
		side_in.mid_x = !lead_x && ({1'b0, pix_in.rel_x} < mid_end_x);
		side_in.mid_y = !lead_y && ({1'b0, pix_in.rel_y} < mid_end_y);
		side_in.alt_x = lead_x ? pix_in.rel_x
			: pix_in.rel_x + settings.sprite_width - settings.dest_width;
		side_in.alt_y = lead_y ? pix_in.rel_y
			: pix_in.rel_y + settings.mid_sh + COORD_W'({settings.corner_height, 1'b0})
			- settings.dest_height;
		side_in.outside = (pix_in.rel_x >= settings.dest_width)
			|| (pix_in.rel_y >= settings.dest_height);
		side_in.screen_x = pix_in.rel_x + COORD_W'(pix_in.origin_x);
		side_in.screen_y = pix_in.rel_y + COORD_W'(pix_in.origin_y);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			dx_s1   <= pix_in.rel_x - COORD_W'(settings.margin_width);
			dy_s1   <= pix_in.rel_y - COORD_W'(settings.corner_height);
		end
	end

	npsm_mod u_mod_x (.clk(clk), .en(en), .num(dx_s1), .div(settings.mid_sw), .rem(rem_x));
	npsm_mod u_mod_y (.clk(clk), .en(en), .num(dy_s1), .div(settings.mid_sh), .rem(rem_y));

	always_ff @(posedge clk) begin
		if (en) begin
			side_smod[0] <= side_s1;
			for (int i = 1; i < MOD_STAGES; i++)
				side_smod[i] <= side_smod[i-1];
		end
	end

	assign side_last = side_smod[MOD_STAGES-1];

	always_comb begin
		sx = side_last.alt_x;
		sy = side_last.alt_y;
		if (side_last.mid_x)
			sx = COORD_W'(settings.margin_width)
				+ ((settings.mid_sw == '0) ? '0 : rem_x);
		if (side_last.mid_y)
			sy = COORD_W'(settings.corner_height)
				+ ((settings.mid_sh == '0) ? '0 : rem_y);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s18 <= sy * settings.sprite_width;
			sx_s18   <= sx;
			side_s18 <= side_last;
		end
	end

	assign lin    = prod_s18[ADDR_W-1:0] + ADDR_W'(sx_s18);
	assign scaled = settings.wide ? {lin[ADDR_W-2:0], 1'b0} : lin;

	always_ff @(posedge clk) begin
		if (en) begin
			scr_x_s19 <= side_s18.screen_x;
			scr_y_s19 <= side_s18.screen_y;
			if (settings.invalid) begin
				status_s19 <= ST_INVALID;
				addr_s19   <= '0;
			end else if (side_s18.outside) begin
				status_s19 <= ST_OUTSIDE;
				addr_s19   <= '0;
			end else begin
				status_s19 <= ST_OK;
				addr_s19   <= scaled + settings.sprite_base;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_smod <= '0;
			v_s18  <= 1'b0;
			v_s19  <= 1'b0;
		end else if (en) begin
			v_s1   <= pix_in.valid;
			v_smod <= {v_smod[MOD_STAGES-2:0], v_s1};
			v_s18  <= v_smod[MOD_STAGES-1];
			v_s19  <= v_s18;
		end
	end

	assign pix_out.valid          = v_s19;
	assign pix_out.source_address = addr_s19;
	assign pix_out.screen_x       = scr_x_s19;
	assign pix_out.screen_y       = scr_y_s19;
	assign pix_out.status         = status_s19;

	`NPSM_ASSERT(a_status_code, clk, arst_n, v_s19 |-> (status_s19 != 2'd3), "bad status code")
	`NPSM_ASSERT(a_err_addr, clk, arst_n, (v_s19 && status_s19 != ST_OK) |-> (addr_s19 == '0), "address on error")
	`NPSM_ASSERT(a_stall_hold, clk, arst_n, (v_s19 && !pix_out.ready) |=> (v_s19 && $stable(addr_s19) && $stable(status_s19)), "output changed in stall")
	`NPSM_ASSERT_RST(a_reset_empty, clk, !arst_n |=> (!v_s1 && !v_s19), "valid during reset")
endmodule

[bench/tb_nine_patch_source_mapper.sv]
// Testbench for the nine-patch source mapper: directed table, directed layouts, then random pixels,
// each result checked against a behavioural address predictor.
// Depends on npsm_pkg, npsm_if and the nine_patch_source_mapper RTL.
`timescale 1ns / 1ps
module tb_nine_patch_source_mapper import npsm_pkg::*; ();

	typedef struct {
		logic [17:0] addr;
		logic [15:0] sx;
		logic [15:0] sy;
		logic [1:0]  st;
	} pix_result_t;

	typedef struct {
		logic [15:0] rx;
		logic [15:0] ry;
		logic [15:0] ox;
		logic [15:0] oy;
		bit          known;
		pix_result_t res;
	} pix_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	npsm_cfg_if cfg ();
	npsm_in_if  pix_in ();
	npsm_out_if pix_out ();

	nine_patch_source_mapper uut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .pix_in(pix_in),
		.pix_out(pix_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [17:0] r_off;
	logic [15:0] r_sw, r_sh, r_dw, r_dh;
	logic [7:0]  r_cw, r_ch;
	logic [1:0]  r_pb;

	pix_result_t expected_q[$];
	int errors = 0;
	bit hold_long = 0;

	function automatic logic [31:0] map_axis(input logic [31:0] rel, corner, msrc, mdst);
		if (rel < corner) return rel;
		if (rel < corner + mdst) return corner + (msrc != 0 ? (rel - corner) % msrc : 0);
		return corner + msrc + (rel - corner - mdst);
	endfunction

	function automatic pix_result_t predict_pixel(input logic [15:0] rx, ry, ox, oy);
		pix_result_t r;
		longint unsigned bytes, two_cw, two_ch, fin, a;
		logic [31:0] msw, msh, mdw, mdh, px, py;
		bytes = (r_pb == 2) ? 2 : 1;
		two_cw = 2 * r_cw;
		two_ch = 2 * r_ch;
		r.addr = '0;
		r.sx = ox + rx;
		r.sy = oy + ry;
		if (r_sw < two_cw || r_sh < two_ch || r_dw < two_cw || r_dh < two_ch) begin
			r.st = ST_INVALID;
		end else begin
			msw = r_sw - two_cw;
			msh = r_sh - two_ch;
			mdw = r_dw - two_cw;
			mdh = r_dh - two_ch;
			fin = longint'(r_off) + longint'(r_sw) * r_sh * bytes;
			if (fin > VRAM_BYTES || (msw == 0 && mdw != 0) || (msh == 0 && mdh != 0)) begin
				r.st = ST_INVALID;
			end else if (rx >= r_dw || ry >= r_dh) begin
				r.st = ST_OUTSIDE;
			end else begin
				px = map_axis(rx, r_cw, msw, mdw);
				py = map_axis(ry, r_ch, msh, mdh);
				a = longint'(r_off) + (longint'(py) * r_sw + px) * bytes;
				r.addr = a[17:0];
				r.st = ST_OK;
			end
		end
		return r;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_SPRITE_BASE:   r_off = val;
			REG_SPRITE_WIDTH:  r_sw = val[15:0];
			REG_SPRITE_HEIGHT: r_sh = val[15:0];
			REG_MARGIN_WIDTH:  r_cw = val[7:0];
			REG_CORNER_HEIGHT: r_ch = val[7:0];
			REG_DEST_WIDTH:    r_dw = val[15:0];
			REG_DEST_HEIGHT:   r_dh = val[15:0];
			default:           r_pb = val[1:0];
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_layout(input logic [17:0] off, input logic [15:0] sw, sh,
			input logic [7:0] cw, ch, input logic [15:0] dw, dh, input logic [1:0] pb);
		pix_in.valid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (25) @(posedge clk);
		write_reg(REG_SPRITE_BASE, off);
		write_reg(REG_SPRITE_WIDTH, sw);
		write_reg(REG_SPRITE_HEIGHT, sh);
		write_reg(REG_MARGIN_WIDTH, cw);
		write_reg(REG_CORNER_HEIGHT, ch);
		write_reg(REG_DEST_WIDTH, dw);
		write_reg(REG_DEST_HEIGHT, dh);
		write_reg(REG_PIXEL_BYTES, pb);
		repeat (4) @(negedge clk);
	endtask

	// one transaction, entered and left at a falling edge; gaps come from the burst pattern
	int burst_left = 0;
	task automatic send_pixel(input logic [15:0] rx, ry, ox, oy);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 2) == 0) begin
				pix_in.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
		burst_left--;
		pix_in.valid <= 1'b1;
		pix_in.rel_x <= rx;
		pix_in.rel_y <= ry;
		pix_in.origin_x <= ox;
		pix_in.origin_y <= oy;
		do @(posedge clk); while (!pix_in.ready);
		expected_q.push_back(predict_pixel(rx, ry, ox, oy));
		@(negedge clk);
	endtask

	task automatic random_pixels(input int n, input logic [15:0] span);
		logic [15:0] rx, ry;
		for (int i = 0; i < n; i++) begin
			rx = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, span));
			ry = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, span));
			send_pixel(rx, ry, 16'($urandom), 16'($urandom));
		end
	endtask

	// receiver stall pattern, with one long hold-off window
	initial begin
		pix_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_long) begin
				pix_out.ready <= 1'b0;
				repeat (120) @(negedge clk);
				hold_long = 0;
			end else if ($urandom_range(0, 99) < 40) begin
				pix_out.ready <= ($urandom_range(0, 3) != 0);
			end else begin
				pix_out.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		pix_result_t e;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected transaction addr=%h", $time, pix_out.source_address);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (pix_out.source_address !== e.addr || pix_out.screen_x !== e.sx ||
						pix_out.screen_y !== e.sy || pix_out.status !== e.st) begin
					$display("%0t: mismatch expected addr=%h x=%h y=%h st=%0d actual addr=%h x=%h y=%h st=%0d",
						$time, e.addr, e.sx, e.sy, e.st, pix_out.source_address,
						pix_out.screen_x, pix_out.screen_y, pix_out.status);
					errors++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	pix_row_t dir_rows[$];

	initial begin
		pix_row_t row;
		pix_result_t p;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		pix_in.valid = 1'b0;
		pix_in.rel_x = '0;
		pix_in.rel_y = '0;
		pix_in.origin_x = '0;
		pix_in.origin_y = '0;
		r_off = 0; r_sw = 0; r_sh = 0; r_cw = 0; r_ch = 0; r_dw = 0; r_dh = 0; r_pb = 1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// after reset: empty rectangle, every pixel outside
		dir_rows.push_back('{16'h0, 16'h0, 16'h0, 16'h0, 1, '{18'h0, 16'h0, 16'h0, ST_OUTSIDE}});
		dir_rows.push_back('{16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 1,
			'{18'h0, 16'h7FFF, 16'h7FFE, ST_OUTSIDE}});
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_pixel(row.rx, row.ry, row.ox, row.oy);
			p = predict_pixel(row.rx, row.ry, row.ox, row.oy);
			if (row.known && (p.addr !== row.res.addr || p.sx !== row.res.sx ||
					p.sy !== row.res.sy || p.st !== row.res.st)) begin
				$display("%0t: directed row %0d expected addr=%h x=%h y=%h st=%0d actual addr=%h x=%h y=%h st=%0d",
					$time, i, row.res.addr, row.res.sx, row.res.sy, row.res.st,
					p.addr, p.sx, p.sy, p.st);
				errors++;
			end
		end

		// regular nine-patch, all regions including tiled middle
		set_layout(18'd100, 16'd20, 16'd12, 8'd4, 8'd3, 16'd50, 16'd30, 2'd2);
		send_pixel(0, 0, 16'h7FFF, 16'h8000);
		send_pixel(3, 2, 0, 0);
		send_pixel(4, 3, 0, 0);
		send_pixel(17, 9, 0, 0);
		send_pixel(45, 26, 0, 0);
		send_pixel(49, 29, 16'hFFFF, 16'hFFFF);
		send_pixel(50, 0, 0, 0);
		send_pixel(0, 30, 0, 0);
		// invalid: corners wider than sprite
		set_layout(18'd0, 16'd6, 16'd6, 8'd4, 8'd1, 16'd20, 16'd20, 2'd1);
		send_pixel(1, 1, 0, 0);
		// invalid: sprite overruns memory
		set_layout(18'h3FFFF, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 2'd2);
		send_pixel(0, 0, 0, 0);
		// invalid: zero source middle with nonzero destination middle
		set_layout(18'd0, 16'd8, 16'd8, 8'd4, 8'd2, 16'd12, 16'd8, 2'd3);
		send_pixel(2, 2, 0, 0);
		// zero middles on both sides: valid
		set_layout(18'd0, 16'd8, 16'd4, 8'd4, 8'd2, 16'd8, 16'd4, 2'd0);
		send_pixel(7, 3, 0, 0);
		// extreme corners, memory exactly full
		set_layout(18'd0, 16'd512, 16'd512, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 2'd1);
		send_pixel(16'hFFFE, 16'hFFFE, 0, 0);
		send_pixel(300, 254, 0, 0);

		// long hold-off so the pipeline backs up
		set_layout(18'd1000, 16'd40, 16'd30, 8'd5, 8'd4, 16'd200, 16'd150, 2'd2);
		hold_long = 1;
		random_pixels(300, 16'd210);

		for (int p = 0; p < 8; p++) begin
			set_layout(18'($urandom_range(0, 2000)), 16'($urandom_range(1, 64)),
				16'($urandom_range(1, 64)), 8'($urandom_range(0, 12)),
				8'($urandom_range(0, 12)), 16'($urandom_range(0, 300)),
				16'($urandom_range(0, 300)), 2'($urandom_range(0, 3)));
			if (r_sw < 2 * r_cw) begin
				write_reg(REG_SPRITE_WIDTH, 18'(2 * r_cw + $urandom_range(0, 5)));
			end
			if (r_sh < 2 * r_ch) begin
				write_reg(REG_SPRITE_HEIGHT, 18'(2 * r_ch + $urandom_range(0, 5)));
			end
			if (r_dw < 2 * r_cw) write_reg(REG_DEST_WIDTH, 18'(2 * r_cw + 7));
			if (r_dh < 2 * r_ch) write_reg(REG_DEST_HEIGHT, 18'(2 * r_ch + 7));
			repeat (4) @(negedge clk);
			random_pixels(130, 16'd320);
		end

		pix_in.valid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
